@@ sv/crl_pkg.sv @@
`timescale 1ns / 1ps
package crl_pkg;

	localparam int unsigned ROM_DEPTH  = 357;
	localparam int unsigned BANDS      = 37;
	localparam int unsigned IDX_W      = 9;
	localparam int unsigned BAND_W     = 6;
	localparam int unsigned DE_W       = 15;
	localparam int unsigned ID_W       = 7;
	localparam int unsigned DEC_OFFSET = 5400;
	localparam int unsigned BAND_STEP  = 300;
	localparam int unsigned BAND_SHIFT = 24;
	localparam int unsigned BAND_RECIP = ((1 << BAND_SHIFT) + BAND_STEP - 1) / BAND_STEP;

	typedef struct packed {
		logic [15:0] ra_lo;
		logic [15:0] ra_hi;
		logic signed [15:0] dec_lo;
		logic [ID_W-1:0] id;
	} bound_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BAND,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic band;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic band_ok;
		logic hit;
		logic last;
	} sts_t;

	function automatic bound_t mk(input int lo, input int hi, input int dl, input int id);
		bound_t b;
		b.ra_lo  = 16'(lo);
		b.ra_hi  = 16'(hi);
		b.dec_lo = 16'(dl);
		b.id     = ID_W'(id);
		return b;
	endfunction

	function automatic logic [IDX_W-1:0] band_start(input logic [BAND_W-1:0] b);
		logic [IDX_W-1:0] r;
		unique case (b)
			6'd0: r = 9'd355;  6'd1: r = 9'd352;  6'd2: r = 9'd343;  6'd3: r = 9'd340;
			6'd4: r = 9'd332;  6'd5: r = 9'd320;  6'd6: r = 9'd303;  6'd7: r = 9'd288;
			6'd8: r = 9'd277;  6'd9: r = 9'd266;  6'd10: r = 9'd257; 6'd11: r = 9'd251;
			6'd12: r = 9'd239; 6'd13: r = 9'd229; 6'd14: r = 9'd221; 6'd15: r = 9'd211;
			6'd16: r = 9'd203; 6'd17: r = 9'd189; 6'd18: r = 9'd177; 6'd19: r = 9'd163;
			6'd20: r = 9'd149; 6'd21: r = 9'd136; 6'd22: r = 9'd124; 6'd23: r = 9'd104;
			6'd24: r = 9'd87;  6'd25: r = 9'd75;  6'd26: r = 9'd69;  6'd27: r = 9'd54;
			6'd28: r = 9'd43;  6'd29: r = 9'd29;  6'd30: r = 9'd23;  6'd31: r = 9'd16;
			6'd32: r = 9'd12;  6'd33: r = 9'd6;   6'd34: r = 9'd4;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/crl_rom.sv @@
`timescale 1ns / 1ps
module crl_rom (
	input  logic                      clk,
	input  logic [crl_pkg::IDX_W-1:0] addr,
	output crl_pkg::bound_t           data
);

	crl_pkg::bound_t rom [crl_pkg::ROM_DEPTH];

	always_comb begin
rom[0]=crl_pkg::mk(0,43200,5280,83); rom[1]=crl_pkg::mk(14400,26100,5190,83);
rom[2]=crl_pkg::mk(37800,41400,5170,83); rom[3]=crl_pkg::mk(32400,37800,5160,83);
rom[4]=crl_pkg::mk(0,14400,5100,18); rom[5]=crl_pkg::mk(16500,19200,4920,13);
rom[6]=crl_pkg::mk(0,9000,4800,18); rom[7]=crl_pkg::mk(19200,26100,4800,13);
rom[8]=crl_pkg::mk(31500,32400,4800,83); rom[9]=crl_pkg::mk(36300,37800,4800,33);
rom[10]=crl_pkg::mk(0,6315,4620,18); rom[11]=crl_pkg::mk(20700,24450,4620,13);
rom[12]=crl_pkg::mk(29760,31500,4500,83); rom[13]=crl_pkg::mk(36300,37200,4500,18);
rom[14]=crl_pkg::mk(14340,16500,4410,13); rom[15]=crl_pkg::mk(16500,20400,4410,33);
rom[16]=crl_pkg::mk(23400,29760,4200,83); rom[17]=crl_pkg::mk(5580,6150,4080,16);
rom[18]=crl_pkg::mk(36750,37200,4020,33); rom[19]=crl_pkg::mk(20400,21600,3990,33);
rom[20]=crl_pkg::mk(0,600,3960,18); rom[21]=crl_pkg::mk(25200,28200,3960,83);
rom[22]=crl_pkg::mk(42450,43200,3960,18); rom[23]=crl_pkg::mk(21600,24300,3840,33);
rom[24]=crl_pkg::mk(24300,25950,3780,33); rom[25]=crl_pkg::mk(41700,42450,3780,18);
rom[26]=crl_pkg::mk(10980,12600,3720,13); rom[27]=crl_pkg::mk(36000,36750,3690,33);
rom[28]=crl_pkg::mk(36966,37080,3655,18); rom[29]=crl_pkg::mk(12600,14340,3600,13);
rom[30]=crl_pkg::mk(14340,15150,3600,82); rom[31]=crl_pkg::mk(35580,36000,3570,33);
rom[32]=crl_pkg::mk(36000,36966,3570,18); rom[33]=crl_pkg::mk(41160,41700,3545,18);
rom[34]=crl_pkg::mk(0,4380,3510,16); rom[35]=crl_pkg::mk(34950,35580,3480,33);
rom[36]=crl_pkg::mk(3060,3435,3450,16); rom[37]=crl_pkg::mk(4380,5580,3420,16);
rom[38]=crl_pkg::mk(5580,5700,3420,13); rom[39]=crl_pkg::mk(40170,41160,3375,18);
rom[40]=crl_pkg::mk(9000,10980,3360,13); rom[41]=crl_pkg::mk(25260,25950,3330,82);
rom[42]=crl_pkg::mk(25950,34950,3330,33); rom[43]=crl_pkg::mk(5700,6000,3300,13);
rom[44]=crl_pkg::mk(39840,40170,3300,18); rom[45]=crl_pkg::mk(37080,39540,3290,18);
rom[46]=crl_pkg::mk(0,3060,3240,16); rom[47]=crl_pkg::mk(10980,11700,3240,50);
rom[48]=crl_pkg::mk(21750,24300,3180,82); rom[49]=crl_pkg::mk(27450,28350,3180,33);
rom[50]=crl_pkg::mk(39540,39840,3165,18); rom[51]=crl_pkg::mk(6000,9000,3150,13);
rom[52]=crl_pkg::mk(41160,42000,3150,16); rom[53]=crl_pkg::mk(28350,30600,3090,33);
rom[54]=crl_pkg::mk(3675,4530,3030,62); rom[55]=crl_pkg::mk(30600,32820,3030,33);
rom[56]=crl_pkg::mk(0,2460,3000,16); rom[57]=crl_pkg::mk(2460,3000,3000,62);
rom[58]=crl_pkg::mk(11700,12240,3000,50); rom[59]=crl_pkg::mk(42000,43200,3000,16);
rom[60]=crl_pkg::mk(24300,25260,2910,82); rom[61]=crl_pkg::mk(0,2010,2880,16);
rom[62]=crl_pkg::mk(42450,43200,2880,16); rom[63]=crl_pkg::mk(32715,32820,2850,39);
rom[64]=crl_pkg::mk(32820,34350,2850,33); rom[65]=crl_pkg::mk(34350,34500,2850,30);
rom[66]=crl_pkg::mk(3000,3675,2820,62); rom[67]=crl_pkg::mk(15150,16500,2820,82);
rom[68]=crl_pkg::mk(300,1560,2760,16); rom[69]=crl_pkg::mk(21600,21750,2700,82);
rom[70]=crl_pkg::mk(12240,13260,2670,50); rom[71]=crl_pkg::mk(39435,39540,2640,30);
rom[72]=crl_pkg::mk(39375,39435,2625,30); rom[73]=crl_pkg::mk(34500,34920,2610,30);
rom[74]=crl_pkg::mk(16500,18300,2520,82); rom[75]=crl_pkg::mk(18300,19410,2400,82);
rom[76]=crl_pkg::mk(27780,28350,2400,8); rom[77]=crl_pkg::mk(28350,29400,2400,39);
rom[78]=crl_pkg::mk(16650,17250,2385,50); rom[79]=crl_pkg::mk(0,4530,2205,0);
rom[80]=crl_pkg::mk(4530,4620,2205,62); rom[81]=crl_pkg::mk(34845,34920,2190,51);
rom[82]=crl_pkg::mk(8100,8445,2160,62); rom[83]=crl_pkg::mk(39120,39375,2160,30);
rom[84]=crl_pkg::mk(39375,39600,2160,45); rom[85]=crl_pkg::mk(11760,13260,2130,7);
rom[86]=crl_pkg::mk(13260,13950,2130,50); rom[87]=crl_pkg::mk(0,3600,2100,0);
rom[88]=crl_pkg::mk(39600,41070,2100,45); rom[89]=crl_pkg::mk(41070,41160,2070,45);
rom[90]=crl_pkg::mk(41160,42300,2070,0); rom[91]=crl_pkg::mk(4620,4890,2040,62);
rom[92]=crl_pkg::mk(19410,19800,2040,82); rom[93]=crl_pkg::mk(21600,22200,2040,11);
rom[94]=crl_pkg::mk(13950,16650,2010,50); rom[95]=crl_pkg::mk(16650,17790,2010,44);
rom[96]=crl_pkg::mk(1290,2535,1980,0); rom[97]=crl_pkg::mk(27330,27780,1980,8);
rom[98]=crl_pkg::mk(42300,42750,1925,0); rom[99]=crl_pkg::mk(22200,23850,1920,11);
rom[100]=crl_pkg::mk(42750,43200,1880,0); rom[101]=crl_pkg::mk(25125,25260,1845,11);
rom[102]=crl_pkg::mk(4350,4890,1840,80); rom[103]=crl_pkg::mk(4890,8100,1840,62);
rom[104]=crl_pkg::mk(8100,8550,1800,7); rom[105]=crl_pkg::mk(32715,34845,1800,51);
rom[106]=crl_pkg::mk(19800,21600,1740,82); rom[107]=crl_pkg::mk(35400,37650,1740,30);
rom[108]=crl_pkg::mk(8550,10590,1710,7); rom[109]=crl_pkg::mk(17790,18900,1710,44);
rom[110]=crl_pkg::mk(23850,25125,1710,11); rom[111]=crl_pkg::mk(0,120,1680,0);
rom[112]=crl_pkg::mk(2535,3000,1680,80); rom[113]=crl_pkg::mk(10590,11760,1680,7);
rom[114]=crl_pkg::mk(14190,14400,1680,37); rom[115]=crl_pkg::mk(37650,39120,1680,30);
rom[116]=crl_pkg::mk(34665,35400,1650,30); rom[117]=crl_pkg::mk(3450,4350,1635,80);
rom[118]=crl_pkg::mk(29100,29400,1620,26); rom[119]=crl_pkg::mk(27150,27330,1560,8);
rom[120]=crl_pkg::mk(27330,29100,1560,26); rom[121]=crl_pkg::mk(33060,33960,1560,51);
rom[122]=crl_pkg::mk(19350,19800,1530,44); rom[123]=crl_pkg::mk(33960,34665,1530,51);
rom[124]=crl_pkg::mk(3000,3450,1500,80); rom[125]=crl_pkg::mk(1290,1530,1425,66);
rom[126]=crl_pkg::mk(18900,19350,1410,44); rom[127]=crl_pkg::mk(38250,38550,1410,87);
rom[128]=crl_pkg::mk(10260,10590,1370,77); rom[129]=crl_pkg::mk(120,255,1320,0);
rom[130]=crl_pkg::mk(28650,28860,1320,73); rom[131]=crl_pkg::mk(10590,11190,1290,37);
rom[132]=crl_pkg::mk(35700,36450,1275,87); rom[133]=crl_pkg::mk(33960,34650,1265,87);
rom[134]=crl_pkg::mk(255,1530,1260,0); rom[135]=crl_pkg::mk(36450,37020,1230,87);
rom[136]=crl_pkg::mk(14055,14190,1200,37); rom[137]=crl_pkg::mk(37020,38250,1170,87);
rom[138]=crl_pkg::mk(34650,35700,1150,87); rom[139]=crl_pkg::mk(5910,6060,1140,6);
rom[140]=crl_pkg::mk(33960,34200,1110,75); rom[141]=crl_pkg::mk(10260,10380,1080,59);
rom[142]=crl_pkg::mk(11190,11355,1050,37); rom[143]=crl_pkg::mk(34200,35700,970,75);
rom[144]=crl_pkg::mk(8940,9600,960,77); rom[145]=crl_pkg::mk(28650,28950,960,39);
rom[146]=crl_pkg::mk(35700,36450,945,75); rom[147]=crl_pkg::mk(8310,8940,930,77);
rom[148]=crl_pkg::mk(9600,10080,930,77); rom[149]=crl_pkg::mk(23100,24300,900,24);
rom[150]=crl_pkg::mk(31050,32850,860,39); rom[151]=crl_pkg::mk(21360,23100,840,24);
rom[152]=crl_pkg::mk(13500,14055,810,37); rom[153]=crl_pkg::mk(30150,31050,770,39);
rom[154]=crl_pkg::mk(0,255,750,61); rom[155]=crl_pkg::mk(10080,10380,750,77);
rom[156]=crl_pkg::mk(12600,13500,750,37); rom[157]=crl_pkg::mk(38010,38400,750,61);
rom[158]=crl_pkg::mk(11355,12480,720,37); rom[159]=crl_pkg::mk(32850,33960,720,39);
rom[160]=crl_pkg::mk(37575,37890,710,31); rom[161]=crl_pkg::mk(37890,38010,710,61);
rom[162]=crl_pkg::mk(20730,21360,660,46); rom[163]=crl_pkg::mk(11235,11355,600,59);
rom[164]=crl_pkg::mk(12480,12600,600,37); rom[165]=crl_pkg::mk(14055,14265,600,22);
rom[166]=crl_pkg::mk(42900,43200,600,61); rom[167]=crl_pkg::mk(3000,5910,595,6);
rom[168]=crl_pkg::mk(36255,36540,510,31); rom[169]=crl_pkg::mk(24300,27150,480,8);
rom[170]=crl_pkg::mk(40950,42900,450,61); rom[171]=crl_pkg::mk(14265,16650,420,22);
rom[172]=crl_pkg::mk(16650,19350,420,46); rom[173]=crl_pkg::mk(32850,33592,375,58);
rom[174]=crl_pkg::mk(33592,33960,375,3); rom[175]=crl_pkg::mk(37500,37575,360,31);
rom[176]=crl_pkg::mk(12600,12630,330,10); rom[177]=crl_pkg::mk(32850,33165,270,88);
rom[178]=crl_pkg::mk(28950,30150,240,39); rom[179]=crl_pkg::mk(32850,33165,180,58);
rom[180]=crl_pkg::mk(38640,39000,165,61); rom[181]=crl_pkg::mk(0,3600,120,66);
rom[182]=crl_pkg::mk(33450,33960,120,88); rom[183]=crl_pkg::mk(36540,37500,120,31);
rom[184]=crl_pkg::mk(37500,38400,120,34); rom[185]=crl_pkg::mk(38400,38640,120,61);
rom[186]=crl_pkg::mk(39600,40950,120,61); rom[187]=crl_pkg::mk(39000,39600,105,61);
rom[188]=crl_pkg::mk(12630,12960,90,10); rom[189]=crl_pkg::mk(6450,8310,0,77);
rom[190]=crl_pkg::mk(8310,8400,0,59); rom[191]=crl_pkg::mk(12960,14550,0,10);
rom[192]=crl_pkg::mk(26400,27150,0,85); rom[193]=crl_pkg::mk(32100,32850,0,58);
rom[194]=crl_pkg::mk(4770,5910,-105,19); rom[195]=crl_pkg::mk(5910,6450,-105,77);
rom[196]=crl_pkg::mk(27150,29280,-195,73); rom[197]=crl_pkg::mk(8400,9150,-240,59);
rom[198]=crl_pkg::mk(10500,11235,-240,59); rom[199]=crl_pkg::mk(32100,32340,-240,88);
rom[200]=crl_pkg::mk(32850,33450,-240,88); rom[201]=crl_pkg::mk(33450,33960,-240,3);
rom[202]=crl_pkg::mk(40950,42900,-240,66); rom[203]=crl_pkg::mk(19350,20730,-360,46);
rom[204]=crl_pkg::mk(20730,21300,-360,85); rom[205]=crl_pkg::mk(0,600,-420,66);
rom[206]=crl_pkg::mk(42900,43200,-420,66); rom[207]=crl_pkg::mk(25650,26400,-480,85);
rom[208]=crl_pkg::mk(28650,29280,-480,58); rom[209]=crl_pkg::mk(36000,36960,-540,3);
rom[210]=crl_pkg::mk(38400,39360,-540,4); rom[211]=crl_pkg::mk(30900,32340,-600,58);
rom[212]=crl_pkg::mk(10500,14550,-660,54); rom[213]=crl_pkg::mk(8850,9150,-660,35);
rom[214]=crl_pkg::mk(9150,10500,-660,59); rom[215]=crl_pkg::mk(14550,15060,-660,41);
rom[216]=crl_pkg::mk(17250,19350,-660,74); rom[217]=crl_pkg::mk(21300,23100,-660,85);
rom[218]=crl_pkg::mk(31650,31800,-700,58); rom[219]=crl_pkg::mk(33960,36000,-722,3);
rom[220]=crl_pkg::mk(8700,8850,-870,35); rom[221]=crl_pkg::mk(36960,38400,-900,4);
rom[222]=crl_pkg::mk(30900,32850,-960,88); rom[223]=crl_pkg::mk(32850,33960,-960,72);
rom[224]=crl_pkg::mk(15060,15450,-1020,41); rom[225]=crl_pkg::mk(29280,29475,-1095,58);
rom[226]=crl_pkg::mk(15450,16350,-1140,41); rom[227]=crl_pkg::mk(19350,19500,-1140,27);
rom[228]=crl_pkg::mk(29280,29475,-1155,71); rom[229]=crl_pkg::mk(28200,28650,-1200,48);
rom[230]=crl_pkg::mk(22650,23100,-1320,29); rom[231]=crl_pkg::mk(23100,25650,-1320,85);
rom[232]=crl_pkg::mk(16350,17550,-1440,41); rom[233]=crl_pkg::mk(3000,4770,-1463,19);
rom[234]=crl_pkg::mk(4770,6750,-1463,35); rom[235]=crl_pkg::mk(19500,21300,-1470,27);
rom[236]=crl_pkg::mk(21300,22650,-1470,29); rom[237]=crl_pkg::mk(25650,26850,-1470,48);
rom[238]=crl_pkg::mk(29280,30150,-1475,58); rom[239]=crl_pkg::mk(0,3000,-1530,19);
rom[240]=crl_pkg::mk(38400,39360,-1530,14); rom[241]=crl_pkg::mk(39360,42900,-1530,4);
rom[242]=crl_pkg::mk(42900,43200,-1530,19); rom[243]=crl_pkg::mk(17550,18450,-1590,41);
rom[244]=crl_pkg::mk(8460,8700,-1635,35); rom[245]=crl_pkg::mk(8700,11010,-1635,47);
rom[246]=crl_pkg::mk(36000,38400,-1680,14); rom[247]=crl_pkg::mk(18450,19050,-1750,41);
rom[248]=crl_pkg::mk(22650,26850,-1770,41); rom[249]=crl_pkg::mk(26850,28200,-1770,48);
rom[250]=crl_pkg::mk(28200,28800,-1770,71); rom[251]=crl_pkg::mk(8250,8460,-1800,35);
rom[252]=crl_pkg::mk(30150,31680,-1800,58); rom[253]=crl_pkg::mk(31680,32100,-1800,76);
rom[254]=crl_pkg::mk(19050,19500,-1870,41); rom[255]=crl_pkg::mk(11010,13260,-1980,9);
rom[256]=crl_pkg::mk(22050,22650,-1980,41); rom[257]=crl_pkg::mk(19500,22050,-2100,41);
rom[258]=crl_pkg::mk(6300,6750,-2160,36); rom[259]=crl_pkg::mk(15060,16860,-2205,68);
rom[260]=crl_pkg::mk(7680,8250,-2220,35); rom[261]=crl_pkg::mk(32100,34500,-2220,76);
rom[262]=crl_pkg::mk(38400,41400,-2220,65); rom[263]=crl_pkg::mk(41400,42000,-2220,70);
rom[264]=crl_pkg::mk(5400,6300,-2375,36); rom[265]=crl_pkg::mk(16860,19800,-2385,1);
rom[266]=crl_pkg::mk(0,3000,-2400,70); rom[267]=crl_pkg::mk(3000,5400,-2400,36);
rom[268]=crl_pkg::mk(6960,7680,-2400,35); rom[269]=crl_pkg::mk(42000,43200,-2400,70);
rom[270]=crl_pkg::mk(25500,26850,-2520,17); rom[271]=crl_pkg::mk(28200,28800,-2520,49);
rom[272]=crl_pkg::mk(28800,29557,-2520,71); rom[273]=crl_pkg::mk(8700,9000,-2580,12);
rom[274]=crl_pkg::mk(9000,11850,-2580,23); rom[275]=crl_pkg::mk(14400,15060,-2580,67);
rom[276]=crl_pkg::mk(6150,6960,-2640,35); rom[277]=crl_pkg::mk(29557,32100,-2730,71);
rom[278]=crl_pkg::mk(32100,34500,-2730,25); rom[279]=crl_pkg::mk(34500,36600,-2730,76);
rom[280]=crl_pkg::mk(36600,38400,-2730,53); rom[281]=crl_pkg::mk(5400,6150,-2760,35);
rom[282]=crl_pkg::mk(8100,8700,-2790,12); rom[283]=crl_pkg::mk(27600,28200,-2880,49);
rom[284]=crl_pkg::mk(0,4200,-2890,63); rom[285]=crl_pkg::mk(4800,5400,-2940,35);
rom[286]=crl_pkg::mk(7350,7680,-2940,40); rom[287]=crl_pkg::mk(7680,8100,-2940,12);
rom[288]=crl_pkg::mk(38400,39600,-3000,38); rom[289]=crl_pkg::mk(10800,14400,-3045,67);
rom[290]=crl_pkg::mk(14400,14700,-3045,84); rom[291]=crl_pkg::mk(4350,4800,-3060,35);
rom[292]=crl_pkg::mk(6900,7350,-3060,40); rom[293]=crl_pkg::mk(0,3300,-3090,63);
rom[294]=crl_pkg::mk(10800,11100,-3150,15); rom[295]=crl_pkg::mk(14700,15210,-3180,84);
rom[296]=crl_pkg::mk(6300,6900,-3190,40); rom[297]=crl_pkg::mk(6900,7200,-3190,32);
rom[298]=crl_pkg::mk(0,2850,-3210,63); rom[299]=crl_pkg::mk(3900,4350,-3240,35);
rom[300]=crl_pkg::mk(8100,9000,-3240,64); rom[301]=crl_pkg::mk(27090,27600,-3240,49);
rom[302]=crl_pkg::mk(15210,15900,-3270,84); rom[303]=crl_pkg::mk(11100,11700,-3300,15);
rom[304]=crl_pkg::mk(21300,23100,-3300,17); rom[305]=crl_pkg::mk(25500,27090,-3300,49);
rom[306]=crl_pkg::mk(27090,27600,-3300,56); rom[307]=crl_pkg::mk(7200,7800,-3390,32);
rom[308]=crl_pkg::mk(15900,19800,-3390,84); rom[309]=crl_pkg::mk(19800,20250,-3390,17);
rom[310]=crl_pkg::mk(31500,32400,-3420,5); rom[311]=crl_pkg::mk(32400,36600,-3420,78);
rom[312]=crl_pkg::mk(39600,42000,-3420,38); rom[313]=crl_pkg::mk(5760,6300,-3450,40);
rom[314]=crl_pkg::mk(9000,9900,-3450,64); rom[315]=crl_pkg::mk(11700,12300,-3480,15);
rom[316]=crl_pkg::mk(0,2400,-3510,63); rom[317]=crl_pkg::mk(2400,3900,-3510,35);
rom[318]=crl_pkg::mk(42000,43200,-3510,63); rom[319]=crl_pkg::mk(7800,8250,-3540,32);
rom[320]=crl_pkg::mk(27600,29557,-3600,56); rom[321]=crl_pkg::mk(36600,38400,-3600,43);
rom[322]=crl_pkg::mk(9900,10800,-3660,64); rom[323]=crl_pkg::mk(27300,27600,-3660,21);
rom[324]=crl_pkg::mk(29557,29850,-3660,5); rom[325]=crl_pkg::mk(26850,27300,-3815,21);
rom[326]=crl_pkg::mk(29850,30150,-3815,5); rom[327]=crl_pkg::mk(10800,12300,-3840,64);
rom[328]=crl_pkg::mk(12300,16260,-3840,15); rom[329]=crl_pkg::mk(20250,21300,-3840,17);
rom[330]=crl_pkg::mk(21300,23100,-3840,28); rom[331]=crl_pkg::mk(23100,26160,-3840,17);
rom[332]=crl_pkg::mk(24300,24600,-3900,21); rom[333]=crl_pkg::mk(30150,30300,-3900,5);
rom[334]=crl_pkg::mk(3900,5760,-4050,40); rom[335]=crl_pkg::mk(5760,8250,-4050,69);
rom[336]=crl_pkg::mk(26550,26850,-4050,21); rom[337]=crl_pkg::mk(30300,31500,-4050,5);
rom[338]=crl_pkg::mk(31500,32400,-4050,60); rom[339]=crl_pkg::mk(39600,42000,-4050,81);
rom[340]=crl_pkg::mk(8250,11850,-4200,32); rom[341]=crl_pkg::mk(24600,26550,-4200,21);
rom[342]=crl_pkg::mk(26550,30600,-4200,79); rom[343]=crl_pkg::mk(0,2400,-4500,81);
rom[344]=crl_pkg::mk(6300,8250,-4500,42); rom[345]=crl_pkg::mk(11850,16260,-4500,86);
rom[346]=crl_pkg::mk(16260,20250,-4500,15); rom[347]=crl_pkg::mk(20250,24600,-4500,55);
rom[348]=crl_pkg::mk(32400,38400,-4500,60); rom[349]=crl_pkg::mk(38400,42000,-4500,43);
rom[350]=crl_pkg::mk(42000,43200,-4500,81); rom[351]=crl_pkg::mk(1350,2400,-4560,81);
rom[352]=crl_pkg::mk(0,6300,-4950,42); rom[353]=crl_pkg::mk(13800,24600,-4950,20);
rom[354]=crl_pkg::mk(24600,32400,-4950,2); rom[355]=crl_pkg::mk(6300,13800,-5100,52);
rom[356]=crl_pkg::mk(0,43200,-5400,57);
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

@@ sv/crl_datapath.sv @@
`timescale 1ns / 1ps
module crl_datapath (
	input  logic                     clk,
	input  logic [15:0]              ra_units,
	input  logic signed [21:0]       dec_fixed,
	input  crl_pkg::cmd_t            cmd,
	output crl_pkg::sts_t            sts,
	output logic                     found,
	output logic [crl_pkg::ID_W-1:0] region_id
);

	logic [15:0]                    ra_q;
	logic signed [crl_pkg::DE_W-1:0] de_q;
	logic [crl_pkg::BAND_W-1:0]     band_q;
	logic                           band_ok_q;
	logic [crl_pkg::IDX_W-1:0]      idx_q;
	logic [crl_pkg::IDX_W-1:0]      rd_idx_q;
	logic                           found_q;
	logic [crl_pkg::ID_W-1:0]       id_q;
	crl_pkg::bound_t                ent;
	logic signed [crl_pkg::DE_W-1:0] de_n;
	logic signed [crl_pkg::DE_W:0]  sum;
	logic [31:0]                    prod;
	logic [crl_pkg::DE_W-1:0]       qfull;
	logic                           ent_hit;

	// floor-ish: truncate toward zero, then one lower for any negative input
	always_comb begin
		de_n = crl_pkg::DE_W'($signed(dec_fixed[21:8]));
		if (dec_fixed[21] && dec_fixed[7:0] != 8'd0) begin
			de_n = de_n + crl_pkg::DE_W'(1);
		end
		if (dec_fixed[21]) begin
			de_n = de_n - crl_pkg::DE_W'(1);
		end
	end

	assign sum   = (crl_pkg::DE_W+1)'(de_q) + (crl_pkg::DE_W+1)'(crl_pkg::DEC_OFFSET);
	// divide by the band step through a reciprocal multiply, exact over 15 bits
	assign prod  = 32'(sum[crl_pkg::DE_W-1:0]) * 32'(crl_pkg::BAND_RECIP);
	assign qfull = crl_pkg::DE_W'(prod >> crl_pkg::BAND_SHIFT);

	crl_rom u_rom (
		.clk  (clk),
		.addr (idx_q),
		.data (ent)
	);

	assign ent_hit = ($signed(ent.dec_lo) <= $signed({de_q[crl_pkg::DE_W-1], de_q}))
		&& (ent.ra_hi > ra_q) && (ent.ra_lo <= ra_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q  <= ra_units;
			de_q  <= de_n;
			found_q <= 1'b0;
			id_q    <= '0;
		end
		if (cmd.band) begin
			// sum < 0 truncates to band 0; sum >= 0 divides
			band_ok_q <= (qfull <= crl_pkg::DE_W'(crl_pkg::BANDS - 1));
			idx_q     <= sum[crl_pkg::DE_W] ? crl_pkg::band_start('0)
				: crl_pkg::band_start(crl_pkg::BAND_W'(qfull));
			band_q    <= crl_pkg::BAND_W'(qfull);
		end
		if (cmd.step) begin
			rd_idx_q <= idx_q;
			idx_q    <= idx_q + crl_pkg::IDX_W'(1);
		end
		if (cmd.finish) begin
			found_q <= ent_hit;
			id_q    <= ent_hit ? ent.id : '0;
		end
	end

	assign sts.band_ok = band_ok_q && (sum[crl_pkg::DE_W] || band_q == crl_pkg::BAND_W'(qfull));
	assign sts.hit     = ent_hit;
	assign sts.last    = (rd_idx_q == crl_pkg::IDX_W'(crl_pkg::ROM_DEPTH - 1));
	assign found       = found_q;
	assign region_id   = id_q;

endmodule

@@ sv/crl_ctrl.sv @@
`timescale 1ns / 1ps
module crl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  crl_pkg::sts_t sts,
	output crl_pkg::cmd_t cmd
);

	crl_pkg::state_t state_q, state_n;
	logic            prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crl_pkg::ST_IDLE;
			prime_q <= 1'b0;
		end else begin
			state_q <= state_n;
			prime_q <= (state_n == crl_pkg::ST_WALK) && (state_q != crl_pkg::ST_WALK);
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			crl_pkg::ST_IDLE: if (in_valid) state_n = crl_pkg::ST_BAND;
			crl_pkg::ST_BAND: state_n = crl_pkg::ST_WALK;
			crl_pkg::ST_WALK: begin
				if (!sts.band_ok) begin
					state_n = crl_pkg::ST_DONE;
				end else if (!prime_q && (sts.hit || sts.last)) begin
					state_n = crl_pkg::ST_DONE;
				end
			end
			crl_pkg::ST_DONE: if (!out_stall) state_n = crl_pkg::ST_IDLE;
			default: state_n = crl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			crl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = 1'b1;
			end
			crl_pkg::ST_BAND: cmd.band = 1'b1;
			crl_pkg::ST_WALK: begin
				cmd.step   = 1'b1;
				cmd.finish = sts.band_ok && !prime_q && (sts.hit || sts.last);
			end
			crl_pkg::ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	ap_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("in and out both open");
	ap_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == crl_pkg::ST_IDLE)) else $error("load outside idle");

endmodule

@@ sv/constellation_region_lookup_unit.sv @@
`timescale 1ns / 1ps
// The walk reads one boundary ROM entry per cycle from the band start until a match, the
// last entry or an out-of-range band, after a band step; ROM reads are registered, and an
// output state then holds the result until it is taken.
// Flow: one item at a time; the next item is accepted the cycle after the result is taken.
// Reset: arst_n asynchronous active low clears the controller to idle; data regs not reset.
module constellation_region_lookup_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [15:0]              ra_units,
	input  logic signed [21:0]       dec_fixed,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     found,
	output logic [crl_pkg::ID_W-1:0] region_id
);

	crl_pkg::cmd_t cmd;
	crl_pkg::sts_t sts;

	crl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	crl_datapath u_dp (
		.clk       (clk),
		.ra_units  (ra_units),
		.dec_fixed (dec_fixed),
		.cmd       (cmd),
		.sts       (sts),
		.found     (found),
		.region_id (region_id)
	);

endmodule
